/* src/bcats_pkg.sv */
// ----------------------------------------------------------------------------
// bcats_pkg: shared definitions for the alpha threshold scanner
// Alpha mode codes, register indexes, field widths and the types that travel
// between the scanner's modules.
// ----------------------------------------------------------------------------
package bcats_pkg;

  // Field widths of the block word and the configuration port.
  localparam int ALPHA_BITS_W = 64;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int MODE_W       = 2;
  localparam int THRESH_W     = 8;

  // Block layout: sixteen texels, 4-bit explicit alphas, 3-bit palette indexes.
  localparam int TEXELS       = 16;
  localparam int NIB_W        = 4;
  localparam int IDX_W        = 3;
  localparam int IDX_BASE     = 16;
  localparam int PAL_ENTRIES  = 8;

  // Interpolation divisors of the two palette shapes.
  localparam int DIV_SIX      = 7;
  localparam int DIV_FOUR     = 5;
  localparam int SUM_W        = 11;

  // Alpha mode codes.
  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXPLICIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INTERP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ASSUMED  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MODE      = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_THRESHOLD = 4'd1;

  // Register values after reset.
  localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_NONE;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd128;

  // Live configuration as seen by the evaluation logic.
  typedef struct packed {
    logic [MODE_W-1:0]   alpha_mode;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

endpackage

/* src/bcats_in_if.sv */
// ----------------------------------------------------------------------------
// bcats_in_if: block input channel
// Valid/ready channel carrying the alpha half of one compressed block per word.
// ----------------------------------------------------------------------------
interface bcats_in_if;
  import bcats_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ALPHA_BITS_W-1:0] alpha_bits;
  logic                    last_block;

  modport source (output valid, output alpha_bits, output last_block, input ready);
  modport sink   (input valid, input alpha_bits, input last_block, output ready);
endinterface

/* src/bcats_out_if.sv */
// ----------------------------------------------------------------------------
// bcats_out_if: result channel
// Valid/ready channel carrying the per-block and per-image threshold flags.
// ----------------------------------------------------------------------------
interface bcats_out_if;
  logic valid;
  logic ready;
  logic block_below;
  logic image_below;
  logic image_done;

  modport source (output valid, output block_below, output image_below,
                  output image_done, input ready);
  modport sink   (input valid, input block_below, input image_below,
                  input image_done, output ready);
endinterface

/* src/bcats_cfg_if.sv */
// ----------------------------------------------------------------------------
// bcats_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface bcats_cfg_if;
  import bcats_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* src/bc_alpha_threshold_scan.sv */
// Path: a block word accepted on the input is held in the input register,
// is evaluated there and is loaded into the result register, from which its
// result word is taken; a stall on the result side can hold it in between.
// Throughput: one block word per cycle; the input side stalls only while both
// registers hold words and the result word is not taken.
// Reset (rst_n low, synchronous): both stages empty, sticky image flag clear,
// alpha_mode none, threshold 128.
// ----------------------------------------------------------------------------
// bc_alpha_threshold_scan: BC2/BC3 alpha cut-out scanner
// Checks every texel alpha of each compressed block against a threshold and
// keeps a sticky per-image flag that clears after the last block.
// ----------------------------------------------------------------------------
module bc_alpha_threshold_scan (
  input  logic          clk,
  input  logic          rst_n,
  bcats_cfg_if.sink     cfg_if,
  bcats_in_if.sink      in_if,
  bcats_out_if.source   out_if
);
  import bcats_pkg::*;

  logic [MODE_W-1:0]       mode_r;
  logic [THRESH_W-1:0]     thresh_r;
  cfg_t                    cfg;

  logic                    s1_valid_r;
  logic [ALPHA_BITS_W-1:0] s1_bits_r;
  logic                    s1_last_r;

  logic                    out_valid_r;
  logic                    out_block_r;
  logic                    out_image_r;
  logic                    out_done_r;

  logic                    seen_r;
  logic                    seen_nxt;
  logic                    image_nxt;
  logic                    block_below;
  logic                    advance;

  // Configuration registers; writes outside the register list are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.addr)
        CFG_IDX_MODE:      mode_r   <= cfg_if.data[MODE_W-1:0];
        CFG_IDX_THRESHOLD: thresh_r <= cfg_if.data[THRESH_W-1:0];
        default:           ;
      endcase
    end
  end

  assign cfg.alpha_mode = mode_r;
  assign cfg.threshold  = thresh_r;

  // Handshake: the input register moves on whenever the result register is
  // free or being drained this cycle.
  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_bits_r <= in_if.alpha_bits;
      s1_last_r <= in_if.last_block;
    end
  end

  // Block evaluation between the two registers.
  bcats_block_eval u_block_eval (
    .cfg         (cfg),
    .alpha_bits  (s1_bits_r),
    .block_below (block_below)
  );

  // Sticky image flag; it restarts once the last block has been handed on.
  assign image_nxt = seen_r | block_below;
  assign seen_nxt  = s1_last_r ? 1'b0 : image_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        seen_r <= seen_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_block_r <= block_below;
      out_image_r <= image_nxt;
      out_done_r  <= s1_last_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.block_below = out_block_r;
  assign out_if.image_below = out_image_r;
  assign out_if.image_done  = out_done_r;

  // A block below threshold always marks its image.
  a_block_marks_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_block_r |-> out_image_r)
    else $error("block flag set without image flag");

  // Handing on the last block of an image clears the sticky flag.
  a_last_clears_seen: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_last_r |=> !seen_r)
    else $error("sticky flag survived the last block");

  // The input side stalls only when both stages are occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> s1_valid_r && out_valid_r && !out_if.ready)
    else $error("input stalled with room in the pipeline");

endmodule

/* src/bcats_interp_hit.sv */
// ----------------------------------------------------------------------------
// bcats_interp_hit: interpolated palette threshold mask
// Flags which of the eight palette entries built from two endpoints lie below
// the threshold. Each interpolated entry is floor(sum / d), and
// floor(sum / d) < thr holds exactly when sum < d * thr, so no divider is built.
// ----------------------------------------------------------------------------
module bcats_interp_hit (
  input  logic [7:0]                     a0,
  input  logic [7:0]                     a1,
  input  logic [bcats_pkg::THRESH_W-1:0] threshold,
  output logic [bcats_pkg::PAL_ENTRIES-1:0] pal_hit
);
  import bcats_pkg::*;

  logic [SUM_W-1:0]       thr_six;
  logic [SUM_W-1:0]       thr_four;
  logic [SUM_W-1:0]       sum_six  [6];
  logic [SUM_W-1:0]       sum_four [4];
  logic [PAL_ENTRIES-1:0] hit_six;
  logic [PAL_ENTRIES-1:0] hit_four;

  // Scaled thresholds for the two divisors.
  assign thr_six  = SUM_W'(DIV_SIX)  * {3'b000, threshold};
  assign thr_four = SUM_W'(DIV_FOUR) * {3'b000, threshold};

  // Weighted endpoint sums; the weights are constants per entry.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sum_six[i] = SUM_W'(6 - i) * {3'b000, a0} + SUM_W'(1 + i) * {3'b000, a1};
    end
    for (int i = 0; i < 4; i++) begin
      sum_four[i] = SUM_W'(4 - i) * {3'b000, a0} + SUM_W'(1 + i) * {3'b000, a1};
    end
  end

  // Six interpolated entries when a0 is above a1.
  always_comb begin
    hit_six[0] = a0 < threshold;
    hit_six[1] = a1 < threshold;
    for (int i = 0; i < 6; i++) begin
      hit_six[2 + i] = sum_six[i] < thr_six;
    end
  end

  // Four interpolated entries plus fixed black and white otherwise.
  // White (255) can never be below an 8-bit threshold.
  always_comb begin
    hit_four[0] = a0 < threshold;
    hit_four[1] = a1 < threshold;
    for (int i = 0; i < 4; i++) begin
      hit_four[2 + i] = sum_four[i] < thr_four;
    end
    hit_four[6] = threshold != '0;
    hit_four[7] = 1'b0;
  end

  assign pal_hit = (a0 > a1) ? hit_six : hit_four;

endmodule

/* src/bcats_block_eval.sv */
// ----------------------------------------------------------------------------
// bcats_block_eval: per-block alpha evaluation
// Decides whether any texel of one block has an alpha below the threshold,
// for the explicit and interpolated encodings and the two fixed modes.
// ----------------------------------------------------------------------------
module bcats_block_eval (
  input  bcats_pkg::cfg_t                  cfg,
  input  logic [bcats_pkg::ALPHA_BITS_W-1:0] alpha_bits,
  output logic                             block_below
);
  import bcats_pkg::*;

  logic [PAL_ENTRIES-1:0] pal_hit;
  logic                   explicit_hit;
  logic                   interp_hit;

  // Palette mask from the two endpoint bytes.
  bcats_interp_hit u_interp_hit (
    .a0        (alpha_bits[7:0]),
    .a1        (alpha_bits[15:8]),
    .threshold (cfg.threshold),
    .pal_hit   (pal_hit)
  );

  // Explicit alphas: n * 17 is the nibble repeated into a byte.
  always_comb begin
    logic [NIB_W-1:0] nib;
    explicit_hit = 1'b0;
    for (int t = 0; t < TEXELS; t++) begin
      nib = alpha_bits[NIB_W*t +: NIB_W];
      explicit_hit = explicit_hit | ({nib, nib} < cfg.threshold);
    end
  end

  // Interpolated alphas: each texel index picks a bit of the palette mask.
  always_comb begin
    logic [IDX_W-1:0] sel;
    interp_hit = 1'b0;
    for (int t = 0; t < TEXELS; t++) begin
      sel = alpha_bits[IDX_BASE + IDX_W*t +: IDX_W];
      interp_hit = interp_hit | pal_hit[sel];
    end
  end

  // Mode select.
  always_comb begin
    case (cfg.alpha_mode)
      MODE_EXPLICIT: block_below = explicit_hit;
      MODE_INTERP:   block_below = interp_hit;
      MODE_ASSUMED:  block_below = 1'b1;
      default:       block_below = 1'b0;
    endcase
  end

endmodule

/* tb/bcats_scan_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcats_scan_checker: result predictor and scoreboard for the alpha scanner
// Watches the configuration, block and result channels. It keeps its own copy
// of the registers and the sticky image flag, works out the flags that each
// accepted block word must produce, and compares every result word with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bcats_scan_checker (
  input  logic        clk,
  input  logic        rst_n,
  bcats_cfg_if        cfg_ch,
  bcats_in_if         in_ch,
  bcats_out_if        out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_results,
  output int unsigned results_seen,
  output int unsigned flagged_blocks
);
  import bcats_pkg::*;

  localparam int NIB_SCALE     = 17;
  localparam int REPORT_LIMIT  = 10;
  localparam int PAL_TOP_ALPHA = 255;

  typedef struct packed {
    logic block_below;
    logic image_below;
    logic image_done;
  } scan_flags_t;

  // Shadow registers and image state.
  logic [MODE_W-1:0]   live_mode;
  logic [THRESH_W-1:0] live_threshold;
  logic                image_cut_seen;
  scan_flags_t         flags_due[$];

  // Explicit alphas: each 4-bit value n stands for n * 17.
  function automatic logic explicit_cutout(input logic [ALPHA_BITS_W-1:0] bits,
                                           input logic [THRESH_W-1:0] thr);
    logic found;
    found = 1'b0;
    for (int t = 0; t < TEXELS; t++)
      if (int'(bits[t*NIB_W +: NIB_W]) * NIB_SCALE < int'(thr)) found = 1'b1;
    return found;
  endfunction

  // Interpolated alphas: build the eight-entry palette from the two
  // endpoints, then look up each texel's 3-bit index.
  function automatic logic interp_cutout(input logic [ALPHA_BITS_W-1:0] bits,
                                         input logic [THRESH_W-1:0] thr);
    int   a0;
    int   a1;
    int   pal [PAL_ENTRIES];
    logic found;
    a0     = int'(bits[7:0]);
    a1     = int'(bits[15:8]);
    found  = 1'b0;
    pal[0] = a0;
    pal[1] = a1;
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++)
        pal[2+i] = ((6 - i) * a0 + (1 + i) * a1) / DIV_SIX;
    end else begin
      for (int i = 0; i < 4; i++)
        pal[2+i] = ((4 - i) * a0 + (1 + i) * a1) / DIV_FOUR;
      pal[6] = 0;
      pal[7] = PAL_TOP_ALPHA;
    end
    for (int t = 0; t < TEXELS; t++)
      if (pal[bits[IDX_BASE + t*IDX_W +: IDX_W]] < int'(thr)) found = 1'b1;
    return found;
  endfunction

  function automatic logic block_has_cutout(input logic [MODE_W-1:0] mode,
                                            input logic [THRESH_W-1:0] thr,
                                            input logic [ALPHA_BITS_W-1:0] bits);
    case (mode)
      MODE_EXPLICIT: return explicit_cutout(bits, thr);
      MODE_INTERP:   return interp_cutout(bits, thr);
      MODE_ASSUMED:  return 1'b1;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // The counters are two-state and start at zero.
  always @(posedge clk) begin
    scan_flags_t want;
    logic        hit;
    if (!rst_n) begin
      live_mode      = MODE_RESET;
      live_threshold = THRESH_RESET;
      image_cut_seen = 1'b0;
      flags_due.delete();
      pending_results <= 0;
    end else begin
      // Result word: compare with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (flags_due.size() == 0) begin
          note_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_seen));
        end else begin
          want = flags_due.pop_front();
          if (out_ch.block_below !== want.block_below ||
              out_ch.image_below !== want.image_below ||
              out_ch.image_done  !== want.image_done) begin
            note_mismatch($sformatf({"result word %0d: expected below=%b image=%b ",
                                     "done=%b, got below=%b image=%b done=%b"},
                                    results_seen, want.block_below, want.image_below,
                                    want.image_done, out_ch.block_below,
                                    out_ch.image_below, out_ch.image_done));
          end
        end
        results_seen++;
        if (out_ch.block_below === 1'b1) flagged_blocks++;
      end

      // Block word: predict its flags with the settings in force now.
      if (in_ch.valid && in_ch.ready) begin
        hit              = block_has_cutout(live_mode, live_threshold, in_ch.alpha_bits);
        image_cut_seen   = image_cut_seen | hit;
        want.block_below = hit;
        want.image_below = image_cut_seen;
        want.image_done  = in_ch.last_block;
        flags_due.push_back(want);
        if (in_ch.last_block) image_cut_seen = 1'b0;
      end

      // Register writes take effect for the next block; other indexes are dropped.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_IDX_MODE:      live_mode      = cfg_ch.data[MODE_W-1:0];
          CFG_IDX_THRESHOLD: live_threshold = cfg_ch.data[THRESH_W-1:0];
          default: ;
        endcase
      end

      pending_results <= flags_due.size();
    end
  end

endmodule

/* tb/bc_alpha_threshold_scan_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bc_alpha_threshold_scan_tb: stimulus and verdict for the alpha scanner
// Drives a directed set of blocks through every alpha mode and the threshold
// extremes, then random phases with shaped blocks under varying sender gaps
// and receiver stalls. A checker beside the scanner predicts and compares.
// ----------------------------------------------------------------------------
module bc_alpha_threshold_scan_tb;
  import bcats_pkg::*;

  localparam int SCAN_LATENCY  = 4;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPARE_FIRST = CFG_IDX_THRESHOLD + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPARE_LAST  = '1;

  localparam logic [MODE_W-1:0] PHASE_MODES [6] = '{MODE_EXPLICIT, MODE_INTERP,
                                                    MODE_NONE, MODE_EXPLICIT,
                                                    MODE_INTERP, MODE_ASSUMED};

  logic        clk;
  logic        rst_n;
  int          send_idle_pct;
  int          stall_pct;
  int unsigned blocks_sent;
  int unsigned images_closed;
  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned results_seen;
  int unsigned flagged_blocks;

  bcats_cfg_if cfg_if ();
  bcats_in_if  in_if ();
  bcats_out_if out_if ();

  bc_alpha_threshold_scan DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  bcats_scan_checker scan_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_ch          (cfg_if),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .flagged_blocks  (flagged_blocks)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side back-pressure; ready settles at the first edge, inside reset.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hard stop for a hung run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // One block word, after a random number of idle cycles.
  task automatic send_block(input logic [ALPHA_BITS_W-1:0] bits, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.alpha_bits <= bits;
    in_if.last_block <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    blocks_sent++;
    if (last) images_closed++;
  endtask

  // Hold the sender until every predicted result word has come back.
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SCAN_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain, then program both registers. Unused mode bits carry random data.
  task automatic set_config(input logic [MODE_W-1:0] mode,
                            input logic [THRESH_W-1:0] thr);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word             = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    wait_results_drained();
    write_reg(CFG_IDX_MODE, mode_word);
    write_reg(CFG_IDX_THRESHOLD, thr);
  endtask

  initial begin
    logic [ALPHA_BITS_W-1:0] bits;
    logic                    last;
    logic [MODE_W-1:0]       cur_mode;
    logic [THRESH_W-1:0]     thr;
    int                      nib_floor;
    int                      idx_hi;
    int                      idx_lo;

    // Stimulus known from time zero; reset held low at the start.
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.alpha_bits = '0;
    in_if.last_block = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.addr      = '0;
    cfg_if.data      = '0;
    stall_pct       <= 0;
    send_idle_pct    = 0;
    blocks_sent      = 0;
    images_closed    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no alpha, so nothing is ever below.
    send_block('0, 1'b1);

    // Explicit alphas against 128: 255 and 136 pass, 119 and 0 are cut out.
    set_config(MODE_EXPLICIT, THRESH_RESET);
    send_block({16{4'hF}}, 1'b0);
    send_block({16{4'h8}}, 1'b0);
    send_block({{15{4'hF}}, 4'h7}, 1'b0);
    send_block({16{4'hF}}, 1'b1);
    send_block('0, 1'b1);

    // Interpolated, seven-step palette (a0 > a1) and five-step palette with
    // the fixed 0 and 255 entries (a0 <= a1, equal endpoints included).
    set_config(MODE_INTERP, THRESH_RESET);
    send_block({{16{3'd0}}, 8'd0, 8'd255}, 1'b0);
    send_block({{16{3'd2}}, 8'd0, 8'd255}, 1'b0);
    send_block({{16{3'd7}}, 8'd0, 8'd255}, 1'b1);
    send_block({{16{3'd7}}, 8'd200, 8'd200}, 1'b0);
    send_block({{16{3'd5}}, 8'd200, 8'd200}, 1'b0);
    send_block({{16{3'd6}}, 8'd200, 8'd200}, 1'b1);
    send_block({{16{3'd2}}, 8'd255, 8'd0}, 1'b1);
    send_block({{15{3'd7}}, 3'd1, 8'd255, 8'd255}, 1'b1);

    // Top threshold: full alpha is not below it, 238 is.
    set_config(MODE_EXPLICIT, '1);
    send_block({16{4'hF}}, 1'b0);
    send_block({{15{4'hF}}, 4'hE}, 1'b1);

    // Zero threshold: nothing can be below, in either decoded mode.
    set_config(MODE_EXPLICIT, '0);
    send_block('0, 1'b1);
    set_config(MODE_INTERP, '0);
    send_block({{16{3'd6}}, 8'd0, 8'd0}, 1'b1);

    // Assumed alpha flags every block.
    set_config(MODE_ASSUMED, THRESH_RESET);
    send_block('1, 1'b0);
    send_block({16{4'hF}}, 1'b1);

    // Mode switched inside an image: the sticky flag keeps its earlier hit.
    // Writes to indexes past the register list must change nothing.
    set_config(MODE_EXPLICIT, THRESH_RESET);
    send_block('0, 1'b0);
    set_config(MODE_NONE, THRESH_RESET);
    write_reg(CFG_IDX_SPARE_FIRST, '1);
    write_reg(CFG_IDX_SPARE_LAST, '0);
    send_block('0, 1'b1);
    send_block('0, 1'b1);

    // Random phases: each with its own mode, threshold and idling profile.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
        1:       begin send_idle_pct = 62; stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  stall_pct <= 62; end
        default: begin send_idle_pct = 17; stall_pct <= 17; end
      endcase
      case (p % 5)
        0:       thr = '0;
        1:       thr = '1;
        default: thr = THRESH_W'($urandom);
      endcase
      cur_mode = PHASE_MODES[p % 6];
      set_config(cur_mode, thr);
      if (p % 3 == 1)
        write_reg(CFG_ADDR_W'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_SPARE_LAST)),
                  CFG_DATA_W'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 3 == 0 && n == PHASE_ITEMS / 2) wait_results_drained();
        bits = {$urandom, $urandom};
        // Half of the blocks in the two decoded modes are shaped so that the answer
        // is not a foregone conclusion: raised nibble floors, or indexes from a narrow range.
        if ($urandom_range(0, 1) == 0) begin
          case (cur_mode)
            MODE_EXPLICIT: begin
              nib_floor = $urandom_range(0, 15);
              for (int t = 0; t < TEXELS; t++)
                bits[t*NIB_W +: NIB_W] = NIB_W'($urandom_range(nib_floor, 15));
            end
            MODE_INTERP: begin
              if ($urandom_range(0, 7) == 0) bits[15:8] = bits[7:0];
              idx_hi = $urandom_range(0, PAL_ENTRIES - 1);
              idx_lo = $urandom_range(0, idx_hi);
              for (int t = 0; t < TEXELS; t++)
                bits[IDX_BASE + t*IDX_W +: IDX_W] = IDX_W'($urandom_range(idx_lo, idx_hi));
            end
            default: ;
          endcase
        end
        last = ($urandom_range(0, 7) == 0);
        send_block(bits, last);
      end
    end

    wait_results_drained();
    $display("Scanned %0d blocks in %0d closed images across all four alpha modes,",
             blocks_sent, images_closed);
    $display("threshold extremes and four idling profiles; %0d of %0d results flagged.",
             flagged_blocks, results_seen);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_results != 0) $display("%0d result words never arrived", pending_results);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bcats_pkg.sv
src/bcats_in_if.sv
src/bcats_out_if.sv
src/bcats_cfg_if.sv
src/bcats_interp_hit.sv
src/bcats_block_eval.sv
src/bc_alpha_threshold_scan.sv
tb/bcats_scan_checker.sv
tb/bc_alpha_threshold_scan_tb.sv
